// ===== design/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OFCC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("ofcc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define OFCC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("ofcc assertion failed");

`endif

// ===== design/ofcc_pkg.sv =====
package ofcc_pkg;

	localparam int MAX_QUADS_DEF  = 64;
	localparam int COORD_BITS_DEF = 24;

	localparam int AXIS_W = 2;
	localparam int TOL_W  = 8;
	localparam int QNUM_W = 6;

	typedef enum logic [2:0] {
		ST_LOAD,     // taking quads
		ST_FETCH_A,  // read quad A
		ST_LATCH_A,  // capture quad A
		ST_SWEEP,    // stream every B against A
		ST_EMIT      // hand A's result to the output register
	} ofcc_state_t;

endpackage

// ===== design/ofcc_ram.sv =====
module ofcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/ofcc_cover_cmp.sv =====
// B removes A: same axis, opposite facing, planes within tol, B's rectangle
// covers A's with tol slack on every edge.
module ofcc_cover_cmp #(
	parameter int COORD_BITS = ofcc_pkg::COORD_BITS_DEF
) (
	input  logic [ofcc_pkg::AXIS_W+1+5*COORD_BITS-1:0] quad_a,
	input  logic [ofcc_pkg::AXIS_W+1+5*COORD_BITS-1:0] quad_b,
	input  logic [ofcc_pkg::TOL_W-1:0]                 tol,
	output logic                                       hit
);

	localparam int CB = COORD_BITS;
	localparam int EW = ofcc_pkg::AXIS_W + 1 + 5 * CB;
	localparam int W  = CB + 2;

	logic [ofcc_pkg::AXIS_W-1:0] ax_a, ax_b;
	logic                        fc_a, fc_b;
	logic signed [CB-1:0] pa_r, pb_r, aul_r, auh_r, avl_r, avh_r, bul_r, buh_r, bvl_r, bvh_r;
	logic signed [W-1:0]  pa, pb, aul, auh, avl, avh, bul, buh, bvl, bvh;
	logic signed [W-1:0]  tol_e, d_ba, d_ab;
	logic                 dir_ok, plane_ok, u_ok, v_ok;

	assign ax_a  = quad_a[EW-1 -: ofcc_pkg::AXIS_W];
	assign ax_b  = quad_b[EW-1 -: ofcc_pkg::AXIS_W];
	assign fc_a  = quad_a[5*CB];
	assign fc_b  = quad_b[5*CB];
	assign pa_r  = quad_a[5*CB-1 -: CB];
	assign aul_r = quad_a[4*CB-1 -: CB];
	assign auh_r = quad_a[3*CB-1 -: CB];
	assign avl_r = quad_a[2*CB-1 -: CB];
	assign avh_r = quad_a[CB-1 -: CB];
	assign pb_r  = quad_b[5*CB-1 -: CB];
	assign bul_r = quad_b[4*CB-1 -: CB];
	assign buh_r = quad_b[3*CB-1 -: CB];
	assign bvl_r = quad_b[2*CB-1 -: CB];
	assign bvh_r = quad_b[CB-1 -: CB];

	// sign-extend so tolerance sums and plane differences cannot wrap
	assign pa  = W'(pa_r);
	assign pb  = W'(pb_r);
	assign aul = W'(aul_r);
	assign auh = W'(auh_r);
	assign avl = W'(avl_r);
	assign avh = W'(avh_r);
	assign bul = W'(bul_r);
	assign buh = W'(buh_r);
	assign bvl = W'(bvl_r);
	assign bvh = W'(bvh_r);
	assign tol_e = W'(tol);

	assign d_ba = pb - pa;
	assign d_ab = pa - pb;

	assign dir_ok   = (ax_a == ax_b) && (fc_a != fc_b);
	assign plane_ok = (d_ba <= tol_e) && (d_ab <= tol_e);
	assign u_ok     = (bul <= aul + tol_e) && (buh >= auh - tol_e);
	assign v_ok     = (bvl <= avl + tol_e) && (bvh >= avh - tol_e);
	assign hit      = dir_ok && plane_ok && u_ok && v_ok;

endmodule

// ===== design/opposing_face_cover_culling_unit.sv =====
// Channel   Handshake               Carries
// input     in_valid / in_ready     normal_axis facing plane_pos u_low u_high v_low v_high last_quad
// output    out_valid / out_ready   quad_number is_removed overflow last_result
// config    cfg_wr_en               cfg_wr_data -> cover_tolerance
//
// A quad without last_quad is taken and written to the quad RAM unless the store is full.
// After the last quad, each stored quad A passes through fetch, latch, a
// read sweep of all n stored quads on the single RAM read port, and emit;
// output stalls lengthen a run, and the RAM read port sets its pace.
// Reset clears count, overflow, tolerance and handshake state; RAM contents
// are not cleared, only entries below the count are ever compared.
// A stalled output holds the sequencer in its emit step; input waits until
// the final result of the run has entered the output register.
module opposing_face_cover_culling_unit #(
	parameter int MAX_QUADS  = ofcc_pkg::MAX_QUADS_DEF,
	parameter int COORD_BITS = ofcc_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_wr_en,
	input  logic [ofcc_pkg::TOL_W-1:0]    cfg_wr_data,
	// quad input
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [ofcc_pkg::AXIS_W-1:0]   normal_axis,
	input  logic                          facing,
	input  logic signed [COORD_BITS-1:0]  plane_pos,
	input  logic signed [COORD_BITS-1:0]  u_low,
	input  logic signed [COORD_BITS-1:0]  u_high,
	input  logic signed [COORD_BITS-1:0]  v_low,
	input  logic signed [COORD_BITS-1:0]  v_high,
	input  logic                          last_quad,
	// result output
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ofcc_pkg::QNUM_W-1:0]   quad_number,
	output logic                          is_removed,
	output logic                          overflow,
	output logic                          last_result
);

	localparam int IDX_W = $clog2(MAX_QUADS);
	localparam int CNT_W = $clog2(MAX_QUADS + 1);
	localparam int EW    = ofcc_pkg::AXIS_W + 1 + 5 * COORD_BITS;

	ofcc_pkg::ofcc_state_t state_q, state_d;

	logic [ofcc_pkg::TOL_W-1:0] tol_q;
	logic [CNT_W-1:0]           count_q;
	logic                       ovf_q;
	logic [IDX_W-1:0]           a_q;
	logic [CNT_W-1:0]           b_q;
	logic [EW-1:0]              a_ent_q;
	logic                       hit_q;
	logic                       rd_vld_s1;
	logic [IDX_W-1:0]           b_s1;

	logic             in_acc, store_full, ram_we, issue, out_load, a_last, cmp_hit;
	logic [IDX_W-1:0] raddr;
	logic [EW-1:0]    wdata, rdata;

	assign in_acc     = in_valid && in_ready;
	assign store_full = (count_q == CNT_W'(MAX_QUADS));
	assign ram_we     = in_acc && !store_full;
	assign a_last     = ((CNT_W'(a_q) + CNT_W'(1)) == count_q);
	assign wdata      = {normal_axis, facing, plane_pos, u_low, u_high, v_low, v_high};
	assign raddr      = (state_q == ofcc_pkg::ST_FETCH_A) ? a_q : b_q[IDX_W-1:0];

	ofcc_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_QUADS)
	) u_quad_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// B comes straight off the RAM output, A from its latch
	ofcc_cover_cmp #(
		.COORD_BITS (COORD_BITS)
	) u_cmp (
		.quad_a (a_ent_q),
		.quad_b (rdata),
		.tol    (tol_q),
		.hit    (cmp_hit)
	);

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		issue    = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ofcc_pkg::ST_LOAD: begin
				in_ready = 1'b1;
				if (in_valid && last_quad) begin
					state_d = ofcc_pkg::ST_FETCH_A;
				end
			end
			ofcc_pkg::ST_FETCH_A: begin
				state_d = ofcc_pkg::ST_LATCH_A;
			end
			ofcc_pkg::ST_LATCH_A: begin
				state_d = ofcc_pkg::ST_SWEEP;
			end
			ofcc_pkg::ST_SWEEP: begin
				if (b_q != count_q) begin
					issue = 1'b1;
				end else begin
					// last compare lands this cycle
					state_d = ofcc_pkg::ST_EMIT;
				end
			end
			ofcc_pkg::ST_EMIT: begin
				out_load = !out_valid || out_ready;
				if (out_load) begin
					state_d = a_last ? ofcc_pkg::ST_LOAD : ofcc_pkg::ST_FETCH_A;
				end
			end
			default: begin
				state_d = ofcc_pkg::ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ofcc_pkg::ST_LOAD;
			tol_q     <= '0;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			a_q       <= '0;
			b_q       <= '0;
			hit_q     <= 1'b0;
			rd_vld_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			if (cfg_wr_en) begin
				tol_q <= cfg_wr_data;
			end
			if (in_acc) begin
				if (store_full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + CNT_W'(1);
				end
				a_q <= '0;
			end
			if (state_q == ofcc_pkg::ST_LATCH_A) begin
				b_q   <= '0;
				hit_q <= 1'b0;
			end
			if (issue) begin
				b_q <= b_q + CNT_W'(1);
			end
			if (rd_vld_s1 && (b_s1 != a_q) && cmp_hit) begin
				hit_q <= 1'b1;
			end
			if (out_load) begin
				out_valid <= 1'b1;
				if (a_last) begin
					count_q <= '0;
					ovf_q   <= 1'b0;
				end else begin
					a_q <= a_q + IDX_W'(1);
				end
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ofcc_pkg::ST_LATCH_A) begin
			a_ent_q <= rdata;
		end
		if (issue) begin
			b_s1 <= b_q[IDX_W-1:0];
		end
		if (out_load) begin
			quad_number <= ofcc_pkg::QNUM_W'(a_q);
			is_removed  <= hit_q;
			overflow    <= ovf_q;
			last_result <= a_last;
		end
	end

endmodule

// ===== design/ofcc_checker.sv =====
`include "assert_macros.svh"

module ofcc_checker #(
	parameter int MAX_QUADS = ofcc_pkg::MAX_QUADS_DEF
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        last_quad,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [ofcc_pkg::QNUM_W-1:0] quad_number,
	input logic                        is_removed,
	input logic                        overflow,
	input logic                        last_result
);

	// stalled result holds
	`OFCC_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(quad_number) && $stable(is_removed) && $stable(overflow) && $stable(last_result))

	// last quad starts culling, input closes
	`OFCC_ASSERT_NXT(a_cull_start, clk, arst_n, in_valid && in_ready && last_quad, !in_ready)

	// mid-run results only while input is closed
	`OFCC_ASSERT_IMP(a_mid_run_busy, clk, arst_n, out_valid && !last_result, !in_ready)

	// overflowed run reports a full store
	`OFCC_ASSERT_IMP(a_ovf_full, clk, arst_n, out_valid && last_result && overflow, quad_number == ofcc_pkg::QNUM_W'(MAX_QUADS - 1))

endmodule

bind opposing_face_cover_culling_unit ofcc_checker #(
	.MAX_QUADS (MAX_QUADS)
) u_ofcc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.last_quad   (last_quad),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.quad_number (quad_number),
	.is_removed  (is_removed),
	.overflow    (overflow),
	.last_result (last_result)
);

// ===== bench/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MQ = ofcc_pkg::MAX_QUADS_DEF;
	localparam int CW = ofcc_pkg::COORD_BITS_DEF;
	localparam int AXIS_W = ofcc_pkg::AXIS_W;
	localparam int TOL_W = ofcc_pkg::TOL_W;
	localparam int QNUM_W = ofcc_pkg::QNUM_W;
	localparam int C_MAX = 2 ** (CW - 1) - 1;
	localparam int C_MIN = -(2 ** (CW - 1));
	// cycles before the watchdog calls it
	localparam int CYCLE_LIMIT = 500_000;
	// settle time after the last result before touching the config port
	localparam int SETTLE = 8;

	// normal axis / facing codes
	localparam logic [AXIS_W-1:0] AXIS_X     = 2'd0;
	localparam logic [AXIS_W-1:0] AXIS_Y     = 2'd1;
	localparam logic [AXIS_W-1:0] AXIS_Z     = 2'd2;
	localparam logic [AXIS_W-1:0] AXIS_SPARE = 2'd3;  // no real axis, still legal
	localparam logic FACE_POS = 1'b0;
	localparam logic FACE_NEG = 1'b1;

	typedef struct {
		logic [AXIS_W-1:0]    axis;
		logic                 facing;
		logic signed [CW-1:0] plane;
		logic signed [CW-1:0] u_lo;
		logic signed [CW-1:0] u_hi;
		logic signed [CW-1:0] v_lo;
		logic signed [CW-1:0] v_hi;
		logic                 last;
	} quad_t;

	typedef struct {
		logic [QNUM_W-1:0] qnum;
		logic              removed;
		logic              ovf;
		logic              last;
	} cull_flag_t;

	// ------------------------------------------------------------------
	// Scoreboard: mirrors the quad store, runs the all-pairs cover test
	// when the closing quad of a mesh comes in, and queues one flag item
	// per stored quad.
	// ------------------------------------------------------------------
	class cull_scoreboard_t;
		quad_t       quads[MQ];
		int unsigned quad_cnt;
		bit          ovf_seen;
		logic [TOL_W-1:0] tol;
		cull_flag_t  flags_due[$];
		int unsigned fails;

		function new();
			quad_cnt = 0;
			ovf_seen = 0;
			tol = '0;
			fails = 0;
		endfunction

		function void set_tolerance(logic [TOL_W-1:0] t);
			tol = t;
		endfunction

		function int unsigned pending();
			return flags_due.size();
		endfunction

		// c covers t with slack tl on every edge
		function bit covers(quad_t c, quad_t t, longint tl);
			return longint'(c.u_lo) <= longint'(t.u_lo) + tl &&
				longint'(c.u_hi) >= longint'(t.u_hi) - tl &&
				longint'(c.v_lo) <= longint'(t.v_lo) + tl &&
				longint'(c.v_hi) >= longint'(t.v_hi) - tl;
		endfunction

		function void note_quad(quad_t q);
			longint tl;
			longint d;
			bit hit;
			int a;
			int b;
			cull_flag_t f;
			if (quad_cnt < MQ) begin
				quads[quad_cnt] = q;
				quad_cnt++;
			end else begin
				ovf_seen = 1;
			end
			if (!q.last)
				return;
			tl = longint'(tol);
			for (a = 0; a < quad_cnt; a++) begin
				hit = 0;
				for (b = 0; b < quad_cnt && !hit; b++) begin
					if (b == a)
						continue;
					if (quads[b].axis != quads[a].axis || quads[b].facing == quads[a].facing)
						continue;
					d = longint'(quads[b].plane) - longint'(quads[a].plane);
					if (d < 0)
						d = -d;
					if (d > tl)
						continue;
					if (covers(quads[b], quads[a], tl))
						hit = 1;
				end
				f.qnum = a[QNUM_W-1:0];
				f.removed = hit;
				f.ovf = ovf_seen;
				f.last = (a + 1 == quad_cnt);
				flags_due = {flags_due, f};
			end
			// mesh done, store starts over
			quad_cnt = 0;
			ovf_seen = 0;
		endfunction

		function void check_result(cull_flag_t got);
			cull_flag_t want;
			if (flags_due.size() == 0) begin
				$error("unexpected result item: quad_number %0d", got.qnum);
				fails++;
				return;
			end
			want = flags_due.pop_front();
			if (got.qnum !== want.qnum) begin
				$error("quad_number: expected %0d, got %0d", want.qnum, got.qnum);
				fails++;
			end
			if (got.removed !== want.removed) begin
				$error("is_removed: expected %0b, got %0b", want.removed, got.removed);
				fails++;
			end
			if (got.ovf !== want.ovf) begin
				$error("overflow: expected %0b, got %0b", want.ovf, got.ovf);
				fails++;
			end
			if (got.last !== want.last) begin
				$error("last_result: expected %0b, got %0b", want.last, got.last);
				fails++;
			end
		endfunction
	endclass

	// ------------------------------------------------------------------
	// DUT hookup; every input has a known value from time zero
	// ------------------------------------------------------------------
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [TOL_W-1:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [AXIS_W-1:0] normal_axis = '0;
	logic facing = 1'b0;
	logic signed [CW-1:0] plane_pos = '0;
	logic signed [CW-1:0] u_low = '0;
	logic signed [CW-1:0] u_high = '0;
	logic signed [CW-1:0] v_low = '0;
	logic signed [CW-1:0] v_high = '0;
	logic last_quad = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [QNUM_W-1:0] quad_number;
	logic is_removed;
	logic overflow;
	logic last_result;

	opposing_face_cover_culling_unit #(
		.MAX_QUADS (MQ),
		.COORD_BITS(CW)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.normal_axis(normal_axis),
		.facing     (facing),
		.plane_pos  (plane_pos),
		.u_low      (u_low),
		.u_high     (u_high),
		.v_low      (v_low),
		.v_high     (v_high),
		.last_quad  (last_quad),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.quad_number(quad_number),
		.is_removed (is_removed),
		.overflow   (overflow),
		.last_result(last_result)
	);

	always #5 clk = ~clk;

	cull_scoreboard_t sb = new();

	// percent chance per cycle of a sender gap / receiver stall
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	// tolerance currently programmed, steers how partners are built
	int cur_tol = 0;

	// Receiver: one NBA per edge, so ready never glitches within a step.
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	// Monitor: values read here are the ones present at the edge, since
	// everything on both sides changes only through NBAs.
	always @(posedge clk) begin
		quad_t q;
		cull_flag_t f;
		if (arst_n && in_valid && in_ready) begin
			q.axis = normal_axis;
			q.facing = facing;
			q.plane = plane_pos;
			q.u_lo = u_low;
			q.u_hi = u_high;
			q.v_lo = v_low;
			q.v_hi = v_high;
			q.last = last_quad;
			sb.note_quad(q);
		end
		if (arst_n && out_valid && out_ready) begin
			f.qnum = quad_number;
			f.removed = is_removed;
			f.ovf = overflow;
			f.last = last_result;
			sb.check_result(f);
		end
	end

	// Watchdog: a hang anywhere ends the run as a failure.
	initial begin
		int unsigned cyc;
		cyc = 0;
		while (cyc < CYCLE_LIMIT) begin
			@(posedge clk);
			cyc++;
		end
		$display("opposing_face_cover_culling_unit verification failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic quad_t mk_quad(logic [AXIS_W-1:0] ax, logic fc, int pl,
			int ul, int uh, int vl, int vh, bit lq);
		quad_t q;
		q.axis = ax;
		q.facing = fc;
		q.plane = CW'(pl);
		q.u_lo = CW'(ul);
		q.u_hi = CW'(uh);
		q.v_lo = CW'(vl);
		q.v_hi = CW'(vh);
		q.last = lq;
		return q;
	endfunction

	// Half the time a small, well-ordered quad near the origin so that
	// random quads overlap; otherwise raw 24-bit noise for bit coverage.
	function automatic quad_t rand_quad();
		quad_t q;
		int lo;
		q.axis = AXIS_W'($urandom_range(3));
		q.facing = 1'($urandom_range(1));
		q.last = 1'b0;
		if ($urandom_range(1)) begin
			q.plane = CW'(int'($urandom_range(600)) - 300);
			lo = int'($urandom_range(2000)) - 1000;
			q.u_lo = CW'(lo);
			q.u_hi = CW'(lo + int'($urandom_range(1500)));
			lo = int'($urandom_range(2000)) - 1000;
			q.v_lo = CW'(lo);
			q.v_hi = CW'(lo + int'($urandom_range(1500)));
		end else begin
			q.plane = CW'($urandom);
			q.u_lo = CW'($urandom);
			q.u_hi = CW'($urandom);
			q.v_lo = CW'($urandom);
			q.v_hi = CW'($urandom);
		end
		return q;
	endfunction

	// offset in [-r, r], zero a quarter of the time
	function automatic int jitter(int r);
		if ($urandom_range(3) == 0)
			return 0;
		return int'($urandom_range(2 * r)) - r;
	endfunction

	// Opposite face of a, nudged around the tolerance boundary on the plane
	// and on each edge; sometimes grown so it covers a by a wide margin.
	function automatic quad_t partner_of(quad_t a, int tl);
		quad_t p;
		int r;
		int grow;
		p = a;
		p.facing = ~a.facing;
		p.last = 1'b0;
		r = tl + 2;
		grow = ($urandom_range(3) == 0) ? int'($urandom_range(400)) : 0;
		p.plane = CW'(a.plane + jitter(r));
		p.u_lo = CW'(a.u_lo + jitter(r) - grow);
		p.u_hi = CW'(a.u_hi + jitter(r) + grow);
		p.v_lo = CW'(a.v_lo + jitter(r) - grow);
		p.v_hi = CW'(a.v_hi + jitter(r) + grow);
		return p;
	endfunction

	// Hold valid across back-to-back items; drop it only for a real gap.
	task automatic send_quad(input quad_t q);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		normal_axis <= q.axis;
		facing <= q.facing;
		plane_pos <= q.plane;
		u_low <= q.u_lo;
		u_high <= q.u_hi;
		v_low <= q.v_lo;
		v_high <= q.v_hi;
		last_quad <= q.last;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// Sender goes quiet until every flag item has been seen, plus settle time.
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// only called with the block idle
	task automatic write_tolerance(input int t);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= t[TOL_W-1:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_tolerance(t[TOL_W-1:0]);
		cur_tol = t;
	endtask

	// One mesh of n quads, the last one closing it. Most quads after the
	// first are opposing partners of earlier ones so the cover logic is hit.
	task automatic run_mesh(input int n);
		quad_t built[$];
		quad_t q;
		for (int i = 0; i < n; i++) begin
			if (built.size() != 0 && $urandom_range(99) < 60)
				q = partner_of(built[$urandom_range(built.size() - 1)], cur_tol);
			else
				q = rand_quad();
			q.last = (i == n - 1);
			built = {built, q};
			send_quad(q);
		end
	endtask

	task automatic run_phase(input int tl, input int s_pct, input int r_pct, input int items);
		int sent;
		int n;
		write_tolerance(tl);
		send_idle_pct = s_pct;
		recv_stall_pct = r_pct;
		sent = 0;
		while (sent < items) begin
			n = ($urandom_range(4) == 0) ? int'($urandom_range(9, 14)) : int'($urandom_range(1, 8));
			run_mesh(n);
			sent += n;
			// first mesh of a phase always waits for its flags before moving on
			if (sent == n || $urandom_range(3) == 0)
				drain();
		end
		drain();
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed meshes, tight tolerance, no idling
		write_tolerance(0);

		// lone quad: nothing to cover it
		send_quad(mk_quad(AXIS_X, FACE_POS, 0, 0, 10, 0, 10, 1));
		drain();

		// equal opposing pair
		send_quad(mk_quad(AXIS_X, FACE_POS, 256, 0, 512, 0, 512, 0));
		send_quad(mk_quad(AXIS_X, FACE_NEG, 256, 0, 512, 0, 512, 0));
		// small face inside a large opposing one: only the small goes
		send_quad(mk_quad(AXIS_Y, FACE_POS, -1000, 10, 20, 10, 20, 0));
		send_quad(mk_quad(AXIS_Y, FACE_NEG, -1000, 0, 100, 0, 100, 0));
		// full-range extents on the top plane
		send_quad(mk_quad(AXIS_Z, FACE_POS, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, 0));
		send_quad(mk_quad(AXIS_Z, FACE_NEG, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, 0));
		// spare axis code pairs only with itself, bottom plane
		send_quad(mk_quad(AXIS_SPARE, FACE_POS, C_MIN, -5, 5, -5, 5, 0));
		send_quad(mk_quad(AXIS_SPARE, FACE_NEG, C_MIN, -5, 5, -5, 5, 0));
		// same geometry on Z must not match the spare-axis faces
		send_quad(mk_quad(AXIS_Z, FACE_POS, C_MIN, -5, 5, -5, 5, 0));
		// duplicate facing of the first pair, still covered by the opposite
		send_quad(mk_quad(AXIS_X, FACE_POS, 256, 0, 512, 0, 512, 0));
		// inverted extents compared as they are
		send_quad(mk_quad(AXIS_Y, FACE_POS, 7, 50, -50, 50, -50, 0));
		send_quad(mk_quad(AXIS_Y, FACE_NEG, 7, 50, -50, 50, -50, 0));
		// plane off by one LSB with zero tolerance
		send_quad(mk_quad(AXIS_X, FACE_NEG, 257, 0, 512, 0, 512, 1));
		drain();

		// widest tolerance: exactly at the slack passes, one past fails
		write_tolerance(255);
		send_quad(mk_quad(AXIS_X, FACE_POS, 0, 0, 1000, 0, 1000, 0));
		send_quad(mk_quad(AXIS_X, FACE_NEG, 255, 255, 745, 255, 745, 0));
		send_quad(mk_quad(AXIS_Y, FACE_POS, 0, 0, 1000, 0, 1000, 0));
		send_quad(mk_quad(AXIS_Y, FACE_NEG, 256, 0, 1000, 0, 1000, 0));
		send_quad(mk_quad(AXIS_Z, FACE_POS, 0, 0, 1000, 0, 1000, 0));
		send_quad(mk_quad(AXIS_Z, FACE_NEG, 0, 256, 1000, 0, 1000, 1));
		drain();

		// random meshes across tolerance and idling mixes
		run_phase(0, 0, 0, 35);
		run_phase(255, 67, 0, 35);
		run_phase(int'($urandom_range(1, 254)), 0, 67, 35);
		run_phase(int'($urandom_range(1, 254)), 32, 32, 35);

		// overfill the store; the closing quad itself is dropped
		write_tolerance(int'($urandom_range(1, 40)));
		send_idle_pct = 32;
		recv_stall_pct = 32;
		run_mesh(MQ + 3);
		drain();

		// anything still queued here is a missing result
		repeat (4 * SETTLE) @(posedge clk);
		if (sb.pending() != 0)
			$error("%0d result items never arrived", sb.pending());
		if (sb.fails == 0 && sb.pending() == 0)
			$display("opposing_face_cover_culling_unit verification clean");
		else
			$display("opposing_face_cover_culling_unit verification failed");
		$finish;
	end

endmodule

// ===== opposing_face_cover_culling_unit.f =====
+incdir+design
design/ofcc_pkg.sv
design/ofcc_ram.sv
design/ofcc_cover_cmp.sv
design/opposing_face_cover_culling_unit.sv
design/ofcc_checker.sv
bench/tb.sv
